// ===== hw/rtl/arp_address_cache_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ARP_ADDRESS_CACHE_TOP_MACROS_SVH
`define ARP_ADDRESS_CACHE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, muted in reset.
`define ARPC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arp cache check failed");

// Next-cycle implication, sampled on the rising clock edge, muted in reset.
`define ARPC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arp cache check failed");

`endif

// ===== hw/rtl/arpc_pkg.sv =====
package arpc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int KEY_W       = 32;
   localparam int MAC_W       = 48;
   localparam int SLOT_W      = 4;

   localparam logic [KEY_W-1:0] BCAST_KEY = {KEY_W{1'b1}};
   localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_LEARN  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ACT_MISS      = 3'd0,
      ACT_HIT       = 3'd1,
      ACT_BCAST     = 3'd2,
      ACT_UPDATED   = 3'd3,
      ACT_INSERTED  = 3'd4,
      ACT_OVERWROTE = 3'd5
   } action_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] ip_key;
      logic [MAC_W-1:0] mac_in;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [MAC_W-1:0]  mac_out;
      logic [SLOT_W-1:0] slot;
      action_type        action;
   } rsp_type;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] key;
      logic [MAC_W-1:0] mac;
   } wr_type;

   // low bits of an entry index, zero-extended when the index is narrower
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/arpc_table.sv =====
module arpc_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [arpc_pkg::IDX_W-1:0] rd_addr,
   input  arpc_pkg::wr_type          wr,
   output logic [arpc_pkg::KEY_W-1:0] rd_key_ff,
   output logic [arpc_pkg::MAC_W-1:0] rd_mac_ff,
   output logic [arpc_pkg::TABLE_DEPTH-1:0] valid_ff
);
   import arpc_pkg::*;

   logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
   logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.key;
         mac_mem[wr.addr] <= wr.mac;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_mac_ff <= mac_mem[rd_addr];
   end

   // valid bits clear at reset, set by any write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

endmodule

// ===== hw/rtl/arpc_seq.sv =====
module arpc_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  arpc_pkg::req_type         req_item,
   output logic                      rsp_strobe,
   output arpc_pkg::rsp_type         rsp_item,
   output logic [arpc_pkg::IDX_W-1:0] rd_addr,
   output arpc_pkg::wr_type          wr,
   input  logic [arpc_pkg::KEY_W-1:0] rd_key,
   input  logic [arpc_pkg::MAC_W-1:0] rd_mac,
   input  logic [arpc_pkg::TABLE_DEPTH-1:0] valid
);
   import arpc_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic hit;
   logic cur_free;
   logic last;

   // shared compare unit: one entry per cycle
   assign hit      = valid[idx_ff] && (rd_key == req_ff.ip_key);
   assign cur_free = !valid[idx_ff];
   assign last     = (idx_ff == IDX_W'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      rd_addr       = '0;
      wr            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_item;
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
            idx_in  = idx_ff + IDX_W'(1);
            if (cur_free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (hit || last) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               if (req_ff.kind == KIND_LOOKUP) begin
                  if (hit) begin
                     rsp_in = '{found: 1'b1, mac_out: rd_mac,
                                slot: slot_of(idx_ff), action: ACT_HIT};
                  end else if (req_ff.ip_key == BCAST_KEY) begin
                     rsp_in = '{found: 1'b1, mac_out: BCAST_MAC,
                                slot: '0, action: ACT_BCAST};
                  end else begin
                     rsp_in = '{found: 1'b0, mac_out: '0,
                                slot: '0, action: ACT_MISS};
                  end
               end else begin
                  // key rewrite is harmless on update: it equals the stored key
                  wr.en  = 1'b1;
                  wr.key = req_ff.ip_key;
                  wr.mac = req_ff.mac_in;
                  rsp_in = '{found: 1'b1, mac_out: '0,
                             slot: '0, action: ACT_OVERWROTE};
                  if (hit) begin
                     wr.addr       = idx_ff;
                     rsp_in.slot   = slot_of(idx_ff);
                     rsp_in.action = ACT_UPDATED;
                  end else if (free_found_ff) begin
                     wr.addr       = free_idx_ff;
                     rsp_in.slot   = slot_of(free_idx_ff);
                     rsp_in.action = ACT_INSERTED;
                  end else if (cur_free) begin
                     wr.addr       = idx_ff;
                     rsp_in.slot   = slot_of(idx_ff);
                     rsp_in.action = ACT_INSERTED;
                  end else begin
                     wr.addr = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== hw/rtl/arp_address_cache_top.sv =====
// ARP address cache: sixteen entries mapping an IPv4 key to a MAC address.
//
// Request channel: present req_item and raise start; the beat is taken on
// the rising edge where start is high and busy is low. busy then stays high
// until the item is finished. kind selects a lookup or a learn.
// Response channel: exactly one beat per request, shown on rsp_item for one
// cycle with rsp_strobe high. There is no back-pressure: the receiver must
// take the beat in that cycle.
// Timing: the shared key comparator walks the table one entry a cycle,
// behind a registered memory read. A request that hits entry i ends the
// scan at entry i; a miss or an insert scans all sixteen. The response
// appears on the cycle after the last scan cycle, and busy drops with it,
// so a new request can be taken then.
// A learn writes the table on the edge that ends the scan.
// Reset: synchronous, active high; clears all valid bits, the sequencer and
// the strobe. Keys and MACs are not cleared: an entry is used only once
// its valid bit is set.
module arp_address_cache_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  arpc_pkg::req_type req_item,
   output logic              rsp_strobe,
   output arpc_pkg::rsp_type rsp_item
);
   import arpc_pkg::*;

   logic [IDX_W-1:0]       rd_addr;
   wr_type                 wr;
   logic [KEY_W-1:0]       rd_key;
   logic [MAC_W-1:0]       rd_mac;
   logic [TABLE_DEPTH-1:0] valid;

   // sequencer and comparator: scan, pick the slot, issue the write
   arpc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .rd_addr    (rd_addr),
      .wr         (wr),
      .rd_key     (rd_key),
      .rd_mac     (rd_mac),
      .valid      (valid)
   );

   // entry storage: key and MAC memories, valid bits in flops
   arpc_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .rd_key_ff (rd_key),
      .rd_mac_ff (rd_mac),
      .valid_ff  (valid)
   );

endmodule

// ===== hw/rtl/arpc_checker.sv =====
`include "arp_address_cache_top_macros.svh"

module arpc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input arpc_pkg::req_type req_item,
   input logic              rsp_strobe,
   input arpc_pkg::rsp_type rsp_item
);
   import arpc_pkg::*;

   logic learn_rsp;

   assign learn_rsp = (rsp_item.action == ACT_UPDATED) ||
                      (rsp_item.action == ACT_INSERTED) ||
                      (rsp_item.action == ACT_OVERWROTE);

   // an accepted beat always makes the block busy in the next cycle
   `ARPC_ASSERT_NXT(a_accept_busy, start && !busy && (req_item.kind == req_item.kind), busy)
   // a response beat closes the item: the block is free again
   `ARPC_ASSERT_IMP(a_rsp_idle, rsp_strobe, !busy)
   // a miss carries no MAC
   `ARPC_ASSERT_IMP(a_miss_zero, rsp_strobe && !rsp_item.found,
                    (rsp_item.mac_out == '0) && (rsp_item.action == ACT_MISS))
   // learns always report found and no MAC
   `ARPC_ASSERT_IMP(a_learn_found, rsp_strobe && learn_rsp,
                    rsp_item.found && (rsp_item.mac_out == '0))

endmodule

bind arp_address_cache_top arpc_checker u_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import arpc_pkg::*;

   // Longest silent stretch of a correct run is one full scan behind the
   // longest sender gap; allow many times that.
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Shadow copy of the table, advanced at each accepted request beat.
   logic [KEY_W-1:0] shadow_key   [TABLE_DEPTH];
   logic [MAC_W-1:0] shadow_mac   [TABLE_DEPTH];
   logic             shadow_valid [TABLE_DEPTH];

   rsp_type pending_replies[$];
   int      fault_count   = 0;
   int      stall_cycles  = 0;
   bit      start_raised  = 1'b0;
   bit      sender_idling = 1'b0;

   arp_address_cache_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Work out the reply to one request and apply its effect to the shadow
   // table: lowest matching valid entry first, then the broadcast rule for
   // lookups, then the first free slot or slot 0 for learns.
   function automatic rsp_type resolve_request(input req_type r);
      rsp_type reply;
      int      hit_idx;
      int      free_idx;
      reply    = '0;
      hit_idx  = -1;
      free_idx = -1;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_key[i] == r.ip_key) hit_idx = i;
         if (!shadow_valid[i]) free_idx = i;
      end
      if (r.kind == KIND_LOOKUP) begin
         if (hit_idx >= 0) begin
            reply.found   = 1'b1;
            reply.mac_out = shadow_mac[hit_idx];
            reply.slot    = SLOT_W'(hit_idx);
            reply.action  = ACT_HIT;
         end else if (r.ip_key == BCAST_KEY) begin
            reply.found   = 1'b1;
            reply.mac_out = BCAST_MAC;
            reply.action  = ACT_BCAST;
         end else begin
            reply.action  = ACT_MISS;
         end
      end else begin
         reply.found = 1'b1;
         if (hit_idx >= 0) begin
            shadow_mac[hit_idx] = r.mac_in;
            reply.slot          = SLOT_W'(hit_idx);
            reply.action        = ACT_UPDATED;
         end else begin
            // no free slot left: fall back to slot 0
            if (free_idx < 0) reply.action = ACT_OVERWROTE;
            else reply.action = ACT_INSERTED;
            if (free_idx < 0) free_idx = 0;
            shadow_key[free_idx]   = r.ip_key;
            shadow_mac[free_idx]   = r.mac_in;
            shadow_valid[free_idx] = 1'b1;
            reply.slot             = SLOT_W'(free_idx);
         end
      end
      return reply;
   endfunction

   function automatic logic [MAC_W-1:0] random_mac();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   // Mostly keys already held, so hits and updates land on every slot; the
   // rest is the broadcast key and fresh keys that miss or evict slot 0.
   function automatic logic [KEY_W-1:0] pick_key();
      int sel;
      int idx;
      sel = $urandom_range(0, 9);
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      if (sel <= 5 && shadow_valid[idx]) return shadow_key[idx];
      if (sel == 6) return BCAST_KEY;
      return $urandom();
   endfunction

   // Send one request beat. Start is raised at a clock edge and held until
   // the edge where busy is low; it is only lowered when a gap follows, so
   // back-to-back beats never toggle it within one time step.
   task automatic send_request(input kind_type k, input logic [KEY_W-1:0] key,
                               input logic [MAC_W-1:0] mac);
      req_type r;
      int      gap;
      r.kind   = k;
      r.ip_key = key;
      r.mac_in = mac;
      gap = (sender_idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         if (start_raised) begin
            start        <= 1'b0;
            start_raised  = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_item     <= r;
      start        <= 1'b1;
      start_raised  = 1'b1;
      do @(posedge clock); while (busy);
      pending_replies.push_back(resolve_request(r));
   endtask

   task automatic send_random_request();
      kind_type k;
      k = ($urandom_range(0, 99) < 55) ? KIND_LOOKUP : KIND_LEARN;
      send_request(k, pick_key(), random_mac());
   endtask

   // Drop start and hold the sender until every outstanding reply has come.
   task automatic wait_for_replies();
      if (start_raised) begin
         start        <= 1'b0;
         start_raised  = 1'b0;
      end
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Empty table, broadcast key, fill to full, update, overwrite of slot 0.
   task automatic test_table_lifecycle();
      send_request(KIND_LOOKUP, BCAST_KEY, random_mac());     // broadcast
      send_request(KIND_LOOKUP, '0, BCAST_MAC);               // miss
      send_request(KIND_LOOKUP, $urandom(), '0);              // miss
      send_request(KIND_LEARN, BCAST_KEY, BCAST_MAC);         // insert slot 0
      send_request(KIND_LOOKUP, BCAST_KEY, '0);               // hit beats broadcast
      send_request(KIND_LEARN, '0, '0);                       // insert slot 1
      send_request(KIND_LEARN, '0, 48'hA5A5_5A5A_F00F);       // update slot 1
      send_request(KIND_LOOKUP, '0, '0);                      // hit slot 1
      for (int i = 2; i < TABLE_DEPTH; i++)
         send_request(KIND_LEARN, 32'h8000_0000 | KEY_W'(i << 8), random_mac());
      send_request(KIND_LOOKUP, 32'h8000_0000 | KEY_W'((TABLE_DEPTH - 1) << 8), '0);
      send_request(KIND_LEARN, 32'h1234_5678, random_mac());  // table full
      send_request(KIND_LOOKUP, BCAST_KEY, '0);               // evicted: broadcast again
   endtask

   // Random traffic with idling switched on and off in stretches.
   task automatic test_mixed_traffic(input int beats);
      for (int n = 0; n < beats; n++) begin
         if (n % 40 == 0) sender_idling = $urandom_range(0, 2) != 0;
         send_random_request();
      end
   endtask

   // Short bursts, each followed by a pause until the cache has answered all.
   task automatic test_drain_pauses(input int rounds, input int burst);
      sender_idling = 1'b1;
      for (int n = 0; n < rounds; n++) begin
         repeat (burst) send_random_request();
         wait_for_replies();
      end
   endtask

   // Closing stretch at full rate, no idling at all.
   task automatic test_back_to_back(input int beats);
      sender_idling = 1'b0;
      repeat (beats) send_random_request();
   endtask

   // Check every reply beat against the oldest prediction, and watch for a
   // stall: a cycle with neither a request nor a reply beat counts toward it.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: reply beat with nothing pending: %p", $time, rsp_item);
               fault_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_item.found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_item.found);
                  fault_count++;
               end
               if (rsp_item.mac_out !== want.mac_out) begin
                  $display("%0t: mac_out expected %h actual %h",
                           $time, want.mac_out, rsp_item.mac_out);
                  fault_count++;
               end
               if (rsp_item.slot !== want.slot) begin
                  $display("%0t: slot expected %0d actual %0d",
                           $time, want.slot, rsp_item.slot);
                  fault_count++;
               end
               if (rsp_item.action !== want.action) begin
                  $display("%0t: action expected %0d actual %0d",
                           $time, want.action, rsp_item.action);
                  fault_count++;
               end
            end
         end
         if (rsp_strobe || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stall_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_key[i]   = '0;
         shadow_mac[i]   = '0;
         shadow_valid[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_table_lifecycle();
      test_mixed_traffic(900);
      test_drain_pauses(6, 25);
      test_back_to_back(500);

      // Drain, then allow a full scan for any stray reply beat.
      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_table.sv
hw/rtl/arpc_seq.sv
hw/rtl/arp_address_cache_top.sv
hw/rtl/arpc_checker.sv
bench/testbench.sv
